// File: hdl/dssm_pkg.sv
package dssm_pkg;

    localparam int MAX_SECTORS_DEFAULT = 32;

    localparam int TRACK_W  = 7;
    localparam int SECTOR_W = 6;
    localparam int STATUS_W = 4;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOCUS_TRACK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SIDED   = 1'd1;

    // input commands
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_MISSING    = 4'd0;
    localparam logic [STATUS_W-1:0] ST_GOOD       = 4'd1;
    localparam logic [STATUS_W-1:0] ST_GOOD_POST1 = 4'd3;

    // zone table
    localparam logic [TRACK_W-1:0] SIDE_TRACKS   = 7'd35;
    localparam logic [TRACK_W-1:0] LAST_TRACK    = 7'd70;
    localparam logic [TRACK_W-1:0] ZONE0_LAST    = 7'd17;
    localparam logic [TRACK_W-1:0] ZONE1_LAST    = 7'd24;
    localparam logic [TRACK_W-1:0] ZONE2_LAST    = 7'd30;
    localparam logic [COUNT_W-1:0] ZONE0_SECTORS = 5'd21;
    localparam logic [COUNT_W-1:0] ZONE1_SECTORS = 5'd19;
    localparam logic [COUNT_W-1:0] ZONE2_SECTORS = 5'd18;
    localparam logic [COUNT_W-1:0] ZONE3_SECTORS = 5'd17;

    typedef struct packed {
        logic                command;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        logic [STATUS_W-1:0] status_code;
    } in_item_t;

    typedef struct packed {
        logic                recorded;
        logic [STATUS_W-1:0] entry_status;
        logic                all_good;
        logic [COUNT_W-1:0]  sectors_in_track;
    } out_item_t;

    typedef struct packed {
        logic latch;
        logic clear;
        logic lookup;
        logic update;
        logic scan_start;
        logic scan_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } dp_status_t;

    function automatic logic [COUNT_W-1:0] zone_sectors(
        input logic [TRACK_W-1:0] track,
        input logic               one_sided
    );
        logic [TRACK_W-1:0] t;
        logic [COUNT_W-1:0] n;
        t = track;
        if (one_sided && t > SIDE_TRACKS)
            t = SIDE_TRACKS;
        if (t > SIDE_TRACKS && t <= LAST_TRACK)
            t = t - SIDE_TRACKS;
        if (t == '0 || t > SIDE_TRACKS)
            n = '0;
        else if (t <= ZONE0_LAST)
            n = ZONE0_SECTORS;
        else if (t <= ZONE1_LAST)
            n = ZONE1_SECTORS;
        else if (t <= ZONE2_LAST)
            n = ZONE2_SECTORS;
        else
            n = ZONE3_SECTORS;
        return n;
    endfunction

endpackage

// File: hdl/dssm_ram.sv
module dssm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/dssm_ctrl.sv
module dssm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_command,
    output logic                in_ready,
    input  dssm_pkg::dp_status_t status,
    output dssm_pkg::dp_cmd_t   cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLEAR  = 6'b000010,
        S_LOOKUP = 6'b000100,
        S_UPDATE = 6'b001000,
        S_SCAN   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (in_command == dssm_pkg::CMD_CLEAR)
                        state_next = S_CLEAR;
                    else
                        state_next = S_LOOKUP;
                end
            end
            S_CLEAR:
            begin
                cmd.clear      = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update     = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold here while the previous item still sits in the output register
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// File: hdl/dssm_datapath.sv
module dssm_datapath #(
    parameter int MaxSectors = dssm_pkg::MAX_SECTORS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dssm_pkg::in_item_t                   in_data,
    input  logic                                 cfg_valid,
    input  logic [dssm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dssm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  dssm_pkg::dp_cmd_t                    cmd,
    output dssm_pkg::dp_status_t                 status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output dssm_pkg::out_item_t                  out_data
);

    localparam int AW = $clog2(MaxSectors);
    localparam int CW = $clog2(MaxSectors + 1);

    dssm_pkg::in_item_t                  item_reg;
    logic [dssm_pkg::TRACK_W-1:0]        focus_track_reg;
    logic                                one_sided_reg;
    logic [MaxSectors-1:0]               valid_reg;
    logic                                held_valid_reg;
    logic                                recorded_reg;
    logic [dssm_pkg::STATUS_W-1:0]       entry_reg;
    logic [CW-1:0]                       scan_idx_reg;
    logic                                chk_reg;
    logic                                chk_valid_reg;
    logic                                good_reg;
    logic                                out_valid_reg;
    dssm_pkg::out_item_t                 out_data_reg;

    logic [dssm_pkg::COUNT_W-1:0]        focus_count;
    logic [dssm_pkg::COUNT_W-1:0]        item_count;
    logic                                sec_ok;
    logic                                in_range;
    logic [dssm_pkg::STATUS_W-1:0]       held;
    logic                                do_write;
    logic                                scan_live;
    logic [dssm_pkg::STATUS_W-1:0]       ram_q;
    logic [AW-1:0]                       sec_addr;
    logic [AW-1:0]                       scan_addr;
    logic [AW-1:0]                       raddr;
    logic [dssm_pkg::STATUS_W-1:0]       eff;
    logic                                eff_good;

    assign focus_count = dssm_pkg::zone_sectors(focus_track_reg, one_sided_reg);
    assign item_count  = dssm_pkg::zone_sectors(item_reg.track, one_sided_reg);
    assign sec_ok      = int'(item_reg.sector) < MaxSectors;
    assign sec_addr    = item_reg.sector[AW-1:0];
    assign in_range    = (item_reg.track == focus_track_reg) && sec_ok
                         && (item_reg.sector < {1'b0, item_count});
    // entries never written since the last clear read as missing
    assign held        = held_valid_reg ? ram_q : dssm_pkg::ST_MISSING;
    assign do_write    = cmd.update && in_range
                         && ((item_reg.status_code != dssm_pkg::ST_MISSING
                              && item_reg.status_code < held)
                             || held == dssm_pkg::ST_MISSING);

    assign scan_live = int'(scan_idx_reg) < int'(focus_count)
                       && int'(scan_idx_reg) < MaxSectors;
    assign scan_addr = scan_idx_reg[AW-1:0];
    assign raddr     = cmd.lookup ? sec_addr : scan_addr;
    assign eff       = chk_valid_reg ? ram_q : dssm_pkg::ST_MISSING;
    assign eff_good  = (eff == dssm_pkg::ST_GOOD) || (eff == dssm_pkg::ST_GOOD_POST1);

    dssm_ram #(
        .WIDTH(dssm_pkg::STATUS_W),
        .DEPTH(MaxSectors)
    ) u_ram (
        .clk  (clk),
        .we   (do_write),
        .waddr(sec_addr),
        .wdata(item_reg.status_code),
        .raddr(raddr),
        .rdata(ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_track_reg <= '0;
            one_sided_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dssm_pkg::CFG_FOCUS_TRACK: focus_track_reg <= cfg_data;
                dssm_pkg::CFG_ONE_SIDED:   one_sided_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.clear)
            valid_reg <= '0;
        else if (do_write)
            valid_reg[sec_addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            item_reg <= in_data;
        if (cmd.lookup)
            held_valid_reg <= sec_ok && valid_reg[sec_addr];
        if (cmd.clear)
        begin
            recorded_reg <= 1'b0;
            entry_reg    <= dssm_pkg::ST_MISSING;
        end
        else if (cmd.update)
        begin
            recorded_reg <= do_write;
            if (do_write)
                entry_reg <= item_reg.status_code;
            else if (sec_ok)
                entry_reg <= held;
            else
                entry_reg <= dssm_pkg::ST_MISSING;
        end
    end

    // scan: read one entry per cycle, check it the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            chk_reg      <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
            chk_reg      <= 1'b0;
        end
        else if (cmd.scan_step && scan_live)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            chk_reg      <= 1'b1;
        end
        else
        begin
            chk_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && scan_live)
            chk_valid_reg <= valid_reg[scan_addr];
        if (cmd.scan_start)
            good_reg <= 1'b1;
        else if (chk_reg && !eff_good)
            good_reg <= 1'b0;
    end

    assign status.scan_done = !scan_live && !chk_reg;
    assign status.out_busy  = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg.recorded         <= recorded_reg;
            out_data_reg.entry_status     <= entry_reg;
            out_data_reg.all_good         <= good_reg;
            out_data_reg.sectors_in_track <= focus_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hdl/disk_sector_status_map_top.sv
// Sector status map for the disk track in focus. Each item is either a sector
// report or a clear command; each gives one result carrying whether the report
// was stored, the entry now held for the addressed sector, whether every sector
// of the focus track reads good or good-post-1, and the focus track's sector
// count. The cost of an item is mainly the scan of the status table over the
// focus track's sector count (0 to 21) of entries, one entry per cycle through
// the single read port of the table memory. One item is in flight at a time; a
// finished result waits in the output register and the next item is accepted
// meanwhile.
// Configuration writes are taken every cycle and must only be issued while idle.
module disk_sector_status_map_top #(
    parameter int MaxSectors = dssm_pkg::MAX_SECTORS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  dssm_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output dssm_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dssm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dssm_pkg::CFG_DATA_W-1:0] cfg_data
);

    dssm_pkg::dp_cmd_t    cmd;
    dssm_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    dssm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_command(in_data.command),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dssm_datapath #(
        .MaxSectors(MaxSectors)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // an accepted item blocks the input until its work is done
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // a track without sectors always reads as all good
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sectors_in_track == '0 |-> out_data.all_good)
        else $error("all_good low for a track with no sectors");

    // nothing can be stored when the focus track has no sectors
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.recorded |-> out_data.sectors_in_track != '0)
        else $error("report stored for a track with no sectors");

    // a freshly stored entry that is not good rules out all_good
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.recorded |-> !out_data.all_good
            || out_data.entry_status == dssm_pkg::ST_GOOD
            || out_data.entry_status == dssm_pkg::ST_GOOD_POST1)
        else $error("all_good high while the stored entry is not good");

endmodule
